FILE: hdl/bounding_box_accumulator_core_defines.svh
// assertion macros for the bounding box accumulator
// expects clk and rst_n in the scope of every use
`ifndef BOUNDING_BOX_ACCUMULATOR_CORE_DEFINES_SVH
`define BOUNDING_BOX_ACCUMULATOR_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define BBA_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence in the same cycle
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the next cycle
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bba_pkg.sv
// shared constants and types for the bounding box accumulator
// no dependencies
package bba_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int AREA_W         = 64;
    localparam int AXIS_W         = 2;
    localparam int NUM_AXES       = 3;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

endpackage

FILE: hdl/bba_vertex_if.sv
// vertex request channel: valid, ready and one vertex
// depends on bba_pkg
interface bba_vertex_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [bba_pkg::FIELD_W-1:0]   vertex_x;
    logic signed [bba_pkg::FIELD_W-1:0]   vertex_y;
    logic signed [bba_pkg::FIELD_W-1:0]   vertex_z;
    logic                                 set_end;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    output set_end, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    input set_end, output ready);

endinterface

FILE: hdl/bba_result_if.sv
// result request channel: valid, ready and one box summary
// depends on bba_pkg
interface bba_result_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [bba_pkg::FIELD_W-1:0]   min_x;
    logic signed [bba_pkg::FIELD_W-1:0]   max_x;
    logic signed [bba_pkg::FIELD_W-1:0]   min_y;
    logic signed [bba_pkg::FIELD_W-1:0]   max_y;
    logic signed [bba_pkg::FIELD_W-1:0]   min_z;
    logic signed [bba_pkg::FIELD_W-1:0]   max_z;
    logic signed [bba_pkg::FIELD_W-1:0]   mid_x;
    logic signed [bba_pkg::FIELD_W-1:0]   mid_y;
    logic signed [bba_pkg::FIELD_W-1:0]   mid_z;
    logic        [bba_pkg::AXIS_W-1:0]    longest_axis;
    logic        [bba_pkg::AREA_W-1:0]    surface_area;

    modport source (output valid, output min_x, output max_x, output min_y, output max_y,
                    output min_z, output max_z, output mid_x, output mid_y, output mid_z,
                    output longest_axis, output surface_area, input ready);
    modport sink   (input valid, input min_x, input max_x, input min_y, input max_y,
                    input min_z, input max_z, input mid_x, input mid_y, input mid_z,
                    input longest_axis, input surface_area, output ready);

endinterface

FILE: hdl/bba_accum.sv
// running box registers and the closed-box snapshot register
// depends on bba_pkg, bba_vertex_if and the assertion macro header
`include "bounding_box_accumulator_core_defines.svh"

module bba_accum #(
    parameter int COORD_BITS = bba_pkg::COORD_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    bba_vertex_if.sink                                       vertex,
    output logic                                             box_valid,
    input  logic                                             box_ready,
    output logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     box_lo,
    output logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     box_hi
);

    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0] coord;
    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0] lo_reg;
    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0] hi_reg;
    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0] lo_next;
    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0] hi_next;
    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0] snap_lo_reg;
    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0] snap_hi_reg;
    logic                                         empty_reg;
    logic                                         snap_valid_reg;
    logic                                         accept;

    assign coord[0] = vertex.vertex_x[COORD_BITS-1:0];
    assign coord[1] = vertex.vertex_y[COORD_BITS-1:0];
    assign coord[2] = vertex.vertex_z[COORD_BITS-1:0];

    assign vertex.ready = !snap_valid_reg || box_ready;
    assign accept       = vertex.valid && vertex.ready;

    // widen each axis, or restart on an empty box
    always_comb
    begin
        for (int a = 0; a < bba_pkg::NUM_AXES; a++)
        begin
            if (empty_reg || ($signed(coord[a]) < $signed(lo_reg[a])))
                lo_next[a] = coord[a];
            else
                lo_next[a] = lo_reg[a];
            if (empty_reg || ($signed(coord[a]) > $signed(hi_reg[a])))
                hi_next[a] = coord[a];
            else
                hi_next[a] = hi_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg      <= 1'b1;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                empty_reg <= vertex.set_end;
            if (vertex.ready)
                snap_valid_reg <= accept && vertex.set_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (accept && vertex.set_end)
        begin
            snap_lo_reg <= lo_next;
            snap_hi_reg <= hi_next;
        end
    end

    assign box_valid = snap_valid_reg;
    assign box_lo    = snap_lo_reg;
    assign box_hi    = snap_hi_reg;

    `BBA_ASSERT_NEXT(a_box_fills, accept && !vertex.set_end, !empty_reg,
        "box still empty after a vertex was taken")
    `BBA_ASSERT_NEXT(a_box_closes, accept && vertex.set_end, empty_reg && snap_valid_reg,
        "closing vertex did not empty the box and post a snapshot")
    `BBA_ASSERT_IMPL(a_snap_order, snap_valid_reg,
        ($signed(snap_lo_reg[0]) <= $signed(snap_hi_reg[0])) &&
        ($signed(snap_lo_reg[1]) <= $signed(snap_hi_reg[1])) &&
        ($signed(snap_lo_reg[2]) <= $signed(snap_hi_reg[2])),
        "snapshot minimum above maximum")

endmodule

FILE: hdl/bba_measure.sv
// extent, centre, longest axis and surface area pipeline with output register
// depends on bba_pkg, bba_result_if and the assertion macro header
`include "bounding_box_accumulator_core_defines.svh"

module bba_measure #(
    parameter int COORD_BITS = bba_pkg::COORD_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             box_valid,
    output logic                                             box_ready,
    input  logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     box_lo,
    input  logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     box_hi,
    bba_result_if.source                                     result
);

    localparam int CW = COORD_BITS;
    localparam int PW = 2 * CW;
    localparam int AW = bba_pkg::AREA_W;
    localparam int XW = AW + 2;
    localparam int FW = bba_pkg::FIELD_W;
    localparam int NA = bba_pkg::NUM_AXES;

    typedef logic [NA-1:0][CW-1:0] coord3_t;

    // stage 1: extents and centres
    logic              m1_valid_reg;
    coord3_t           m1_lo_reg, m1_hi_reg, m1_mid_reg, m1_ext_reg;
    coord3_t           ext_next, mid_next;
    logic [CW:0]       mid_sum [NA];

    // stage 2: products and longest axis
    logic              m2_valid_reg;
    coord3_t           m2_lo_reg, m2_hi_reg, m2_mid_reg, m2_ext_reg;
    logic [PW-1:0]     m2_pxy_reg, m2_pxz_reg, m2_pyz_reg;
    bba_pkg::axis_t    m2_axis_reg, axis_next;

    // stage 3: partial sum
    logic              m3_valid_reg;
    coord3_t           m3_lo_reg, m3_hi_reg, m3_mid_reg;
    bba_pkg::axis_t    m3_axis_reg;
    logic [PW:0]       m3_partial_reg;
    logic [PW-1:0]     m3_pyz_reg;

    // output register
    logic              o_valid_reg;
    coord3_t           o_lo_reg, o_hi_reg, o_mid_reg;
    bba_pkg::axis_t    o_axis_reg;
    logic [AW-1:0]     o_area_reg, area_next;
    logic [XW-1:0]     area_sum;

    logic              rdy1, rdy2, rdy3, rdy_o;

    assign rdy_o     = !o_valid_reg || result.ready;
    assign rdy3      = !m3_valid_reg || rdy_o;
    assign rdy2      = !m2_valid_reg || rdy3;
    assign rdy1      = !m1_valid_reg || rdy2;
    assign box_ready = rdy1;

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            ext_next[a] = box_hi[a] - box_lo[a];
            mid_sum[a]  = {box_lo[a][CW-1], box_lo[a]} + {box_hi[a][CW-1], box_hi[a]};
            mid_next[a] = mid_sum[a][CW:1];
        end
    end

    always_comb
    begin
        if ((m1_ext_reg[0] >= m1_ext_reg[1]) && (m1_ext_reg[0] >= m1_ext_reg[2]))
            axis_next = bba_pkg::AXIS_X;
        else if (m1_ext_reg[1] >= m1_ext_reg[2])
            axis_next = bba_pkg::AXIS_Y;
        else
            axis_next = bba_pkg::AXIS_Z;
    end

    // sum at or above half range saturates after doubling
    always_comb
    begin
        area_sum = XW'(m3_partial_reg) + XW'(m3_pyz_reg);
        if (|area_sum[XW-1:AW-1])
            area_next = '1;
        else
            area_next = {area_sum[AW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rdy1)
                m1_valid_reg <= box_valid;
            if (rdy2)
                m2_valid_reg <= m1_valid_reg;
            if (rdy3)
                m3_valid_reg <= m2_valid_reg;
            if (rdy_o)
                o_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && box_valid)
        begin
            m1_lo_reg  <= box_lo;
            m1_hi_reg  <= box_hi;
            m1_mid_reg <= mid_next;
            m1_ext_reg <= ext_next;
        end
        if (rdy2 && m1_valid_reg)
        begin
            m2_lo_reg   <= m1_lo_reg;
            m2_hi_reg   <= m1_hi_reg;
            m2_mid_reg  <= m1_mid_reg;
            m2_ext_reg  <= m1_ext_reg;
            m2_axis_reg <= axis_next;
            m2_pxy_reg  <= PW'(m1_ext_reg[0]) * PW'(m1_ext_reg[1]);
            m2_pxz_reg  <= PW'(m1_ext_reg[0]) * PW'(m1_ext_reg[2]);
            m2_pyz_reg  <= PW'(m1_ext_reg[1]) * PW'(m1_ext_reg[2]);
        end
        if (rdy3 && m2_valid_reg)
        begin
            m3_lo_reg      <= m2_lo_reg;
            m3_hi_reg      <= m2_hi_reg;
            m3_mid_reg     <= m2_mid_reg;
            m3_axis_reg    <= m2_axis_reg;
            m3_partial_reg <= (PW+1)'(m2_pxy_reg) + (PW+1)'(m2_pxz_reg);
            m3_pyz_reg     <= m2_pyz_reg;
        end
        if (rdy_o && m3_valid_reg)
        begin
            o_lo_reg   <= m3_lo_reg;
            o_hi_reg   <= m3_hi_reg;
            o_mid_reg  <= m3_mid_reg;
            o_axis_reg <= m3_axis_reg;
            o_area_reg <= area_next;
        end
    end

    assign result.valid        = o_valid_reg;
    assign result.min_x        = FW'($signed(o_lo_reg[0]));
    assign result.max_x        = FW'($signed(o_hi_reg[0]));
    assign result.min_y        = FW'($signed(o_lo_reg[1]));
    assign result.max_y        = FW'($signed(o_hi_reg[1]));
    assign result.min_z        = FW'($signed(o_lo_reg[2]));
    assign result.max_z        = FW'($signed(o_hi_reg[2]));
    assign result.mid_x        = FW'($signed(o_mid_reg[0]));
    assign result.mid_y        = FW'($signed(o_mid_reg[1]));
    assign result.mid_z        = FW'($signed(o_mid_reg[2]));
    assign result.longest_axis = o_axis_reg;
    assign result.surface_area = o_area_reg;

    `BBA_ASSERT_IMPL(a_axis_longest, m2_valid_reg,
        ((m2_axis_reg == bba_pkg::AXIS_X) && (m2_ext_reg[0] >= m2_ext_reg[1]) &&
         (m2_ext_reg[0] >= m2_ext_reg[2])) ||
        ((m2_axis_reg == bba_pkg::AXIS_Y) && (m2_ext_reg[1] > m2_ext_reg[0]) &&
         (m2_ext_reg[1] >= m2_ext_reg[2])) ||
        ((m2_axis_reg == bba_pkg::AXIS_Z) && (m2_ext_reg[2] > m2_ext_reg[0]) &&
         (m2_ext_reg[2] > m2_ext_reg[1])),
        "chosen axis is not the longest")
    `BBA_ASSERT_IMPL(a_mid_inside, m1_valid_reg,
        ($signed(m1_lo_reg[0]) <= $signed(m1_mid_reg[0])) &&
        ($signed(m1_mid_reg[0]) <= $signed(m1_hi_reg[0])) &&
        ($signed(m1_lo_reg[1]) <= $signed(m1_mid_reg[1])) &&
        ($signed(m1_mid_reg[1]) <= $signed(m1_hi_reg[1])) &&
        ($signed(m1_lo_reg[2]) <= $signed(m1_mid_reg[2])) &&
        ($signed(m1_mid_reg[2]) <= $signed(m1_hi_reg[2])),
        "centre outside the box")
    `BBA_ASSERT_NEXT(a_stage3_hold, m3_valid_reg && !rdy_o,
        m3_valid_reg && $stable(m3_partial_reg),
        "partial area lost while the output stalls")

endmodule

FILE: hdl/bounding_box_accumulator_core.sv
// top level of the bounding box accumulator
// depends on bba_pkg, bba_vertex_if, bba_result_if, bba_accum and bba_measure
//
// vertex channel: one vertex per request, signed Q16.16 x, y, z plus set_end.
// the low COORD_BITS bits of each coordinate are used, read as two's complement.
// result channel: one request per set, posted for the vertex flagged set_end,
// carrying the six bounds, floor centre per axis, longest axis (ties x, then y)
// and twice the summed face areas in Q32.32, saturating at all ones.
// throughput: one vertex per cycle while vertex.ready is high, set by the compare and select that widens
// the box registers; sets of any length may follow each other directly.
// path: the closed box is registered in the snapshot at the edge that takes the closing
// vertex, then passes the extents, products, partial sum and output register stages.
// reset: the box is empty and no result is pending; the first vertex starts a box.
// stall: a held result keeps its value; up to five closed sets queue in the
// snapshot and pipeline, then vertex.ready drops until result.ready frees a stage.
module bounding_box_accumulator_core #(
    parameter int COORD_BITS = bba_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bba_vertex_if.sink    vertex,
    bba_result_if.source  result
);

    logic                                          box_valid;
    logic                                          box_ready;
    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0]  box_lo;
    logic [bba_pkg::NUM_AXES-1:0][COORD_BITS-1:0]  box_hi;

    bba_accum #(
        .COORD_BITS (COORD_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vertex),
        .box_valid (box_valid),
        .box_ready (box_ready),
        .box_lo    (box_lo),
        .box_hi    (box_hi)
    );

    bba_measure #(
        .COORD_BITS (COORD_BITS)
    ) u_measure (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_valid (box_valid),
        .box_ready (box_ready),
        .box_lo    (box_lo),
        .box_hi    (box_hi),
        .result    (result)
    );

endmodule
